@@ sv/sdc_pkg.sv @@
package sdc_pkg;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  byte_address;
      logic [31:0] write_data;
      logic [7:0]  slave_in_byte;
   } sdc_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        byte_exchanged;
      logic [7:0]  slave_out_byte;
      logic [1:0]  active_select;
      logic [2:0]  release_mask;
      logic        tx_dma_request;
      logic        rx_dma_request;
      logic [1:0]  access_error;
   } sdc_rsp_type;

   typedef struct packed {
      logic commit;
   } sdc_cmd_type;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_ADDR  = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;

   localparam logic [7:0] LAST_ADDR = 8'h38;

   localparam logic [3:0] REG_SETUP0   = 4'd0;
   localparam logic [3:0] REG_SETUP1   = 4'd1;
   localparam logic [3:0] REG_SETUP2   = 4'd2;
   localparam logic [3:0] REG_CONTROL  = 4'd3;
   localparam logic [3:0] REG_SETUP4   = 4'd4;
   localparam logic [3:0] REG_SEND     = 4'd5;
   localparam logic [3:0] REG_GET      = 4'd6;
   localparam logic [3:0] REG_RD_STAT  = 4'd7;
   localparam logic [3:0] REG_RD_EN    = 4'd8;
   localparam logic [3:0] REG_RD_CLR   = 4'd9;
   localparam logic [3:0] REG_WR_STAT  = 4'd10;
   localparam logic [3:0] REG_WR_EN    = 4'd11;
   localparam logic [3:0] REG_WR_CLR   = 4'd12;

   localparam int FL_SEND_BIT = 0;
   localparam int FL_RECV_BIT = 1;
   localparam int FL_CONT_BIT = 2;

   localparam logic [12:0] COUNT_FULL = 13'h1000;

endpackage

@@ sv/sdc_req_if.sv @@
interface sdc_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  byte_address;
   logic [31:0] write_data;
   logic [7:0]  slave_in_byte;

   modport source (output valid, output cmd, output byte_address, output write_data,
                   output slave_in_byte, input ready);
   modport sink (input valid, input cmd, input byte_address, input write_data,
                 input slave_in_byte, output ready);
endinterface

@@ sv/sdc_rsp_if.sv @@
interface sdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        byte_exchanged;
   logic [7:0]  slave_out_byte;
   logic [1:0]  active_select;
   logic [2:0]  release_mask;
   logic        tx_dma_request;
   logic        rx_dma_request;
   logic [1:0]  access_error;

   modport source (output valid, output read_data, output byte_exchanged,
                   output slave_out_byte, output active_select, output release_mask,
                   output tx_dma_request, output rx_dma_request, output access_error,
                   input ready);
   modport sink (input valid, input read_data, input byte_exchanged,
                 input slave_out_byte, input active_select, input release_mask,
                 input tx_dma_request, input rx_dma_request, input access_error,
                 output ready);
endinterface

@@ sv/sdc_controller.sv @@
module sdc_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sdc_pkg::sdc_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RESP = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign cmd.commit = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted transfer always produces exactly one pending result.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (rsp_valid && !req_ready))
      else $error("accepted transfer did not produce a result");

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (req_ready && !rsp_valid))
      else $error("controller did not return to idle after result transfer");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and result sides active together");

endmodule

@@ sv/sdc_datapath.sv @@
module sdc_datapath #(
   parameter int NUM_SELECTS = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sdc_pkg::sdc_cmd_type cmd,
   input  sdc_pkg::sdc_req_type req,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_write_data,
   output sdc_pkg::sdc_rsp_type rsp
);

   typedef struct packed {
      logic [31:0] sw0;
      logic [31:0] sw1;
      logic [31:0] sw2;
      logic [11:0] sw4;
      logic [2:0]  ctl;     // stored control bits 29, 28 and 26
      logic [12:0] qcount;
      logic [2:0]  qflags;
      logic [1:0]  qsel;
      logic [12:0] scnt;
      logic [12:0] rcnt;
      logic [2:0]  cflags;
      logic [1:0]  csel;
      logic [3:0]  ris;
      logic [3:0]  rie;
      logic [4:0]  wis;
      logic [4:0]  wie;
      logic [1:0]  dma;
      logic [2:0]  rel;
   } sdc_state_type;

   localparam sdc_state_type STATE_RESET = '{ris: 4'h1, wis: 5'h11, default: '0};
   localparam logic [2:0] SEL_MASK = 3'((1 << NUM_SELECTS) - 1);

   sdc_state_type        state_ff, state_in, s;
   sdc_pkg::sdc_rsp_type rsp_ff, rsp_in;
   logic [2:0]           mask_ff;
   logic [3:0]           regi;
   logic [31:0]          rd;
   logic                 xch;
   logic [7:0]           sout;
   logic [1:0]           err;

   function automatic logic attached(input logic [1:0] sel, input logic [2:0] m);
      logic r;
      r = 1'b0;
      if (int'(sel) < NUM_SELECTS) begin
         case (sel)
            2'd0:    r = m[0];
            2'd1:    r = m[1];
            2'd2:    r = m[2];
            default: r = 1'b0;
         endcase
      end
      return r;
   endfunction

   function automatic logic is_idle(input sdc_state_type st);
      return (st.scnt == 13'd0) && (st.rcnt == 13'd0);
   endfunction

   function automatic sdc_state_type end_txn(input sdc_state_type st, input logic [2:0] m);
      sdc_state_type r;
      r = st;
      if (r.cflags[sdc_pkg::FL_SEND_BIT] || r.cflags[sdc_pkg::FL_RECV_BIT]) begin
         r.cflags[sdc_pkg::FL_SEND_BIT] = 1'b0;
         r.cflags[sdc_pkg::FL_RECV_BIT] = 1'b0;
         if (attached(r.csel, m)) r.rel = r.rel | 3'(3'b001 << r.csel);
         r.wis[4] = 1'b1;
      end
      return r;
   endfunction

   function automatic sdc_state_type refresh(input sdc_state_type st);
      sdc_state_type r;
      r = st;
      if (is_idle(r)) begin
         r.dma = r.qflags[1:0];
         if (r.qflags[sdc_pkg::FL_RECV_BIT]) r.wis[1] = 1'b1;
      end else begin
         r.dma = 2'b00;
      end
      return r;
   endfunction

   function automatic sdc_state_type promote(input sdc_state_type st, input logic [2:0] m);
      sdc_state_type r;
      r = st;
      if (r.csel != r.qsel) r = end_txn(r, m);
      r.cflags = r.qflags;
      r.csel   = r.qsel;
      r.rcnt   = r.qflags[sdc_pkg::FL_RECV_BIT] ? r.qcount : 13'd0;
      r.scnt   = r.qflags[sdc_pkg::FL_SEND_BIT] ? r.qcount : 13'd0;
      r.qflags = r.qflags & 3'b100;
      r = refresh(r);
      return r;
   endfunction

   function automatic sdc_state_type finish(input sdc_state_type st, input logic [2:0] m);
      sdc_state_type r;
      r = st;
      if (!r.cflags[sdc_pkg::FL_CONT_BIT]) r = end_txn(r, m);
      r = refresh(r);
      r.ris[0] = 1'b1;
      r.wis[0] = 1'b1;
      return r;
   endfunction

   assign regi = req.byte_address[5:2];

   always_comb begin
      s     = state_ff;
      s.rel = 3'b000;
      rd    = 32'd0;
      xch   = 1'b0;
      sout  = 8'd0;
      err   = sdc_pkg::ERR_OK;
      if (req.byte_address[1:0] != 2'b00 || req.byte_address > sdc_pkg::LAST_ADDR) begin
         err = sdc_pkg::ERR_ADDR;
      end else if (req.cmd == sdc_pkg::CMD_WRITE) begin
         unique case (regi)
            sdc_pkg::REG_SETUP0: s.sw0 = req.write_data;
            sdc_pkg::REG_SETUP1: s.sw1 = req.write_data;
            sdc_pkg::REG_SETUP2: s.sw2 = req.write_data;
            sdc_pkg::REG_CONTROL: begin
               s.ctl    = {req.write_data[29], req.write_data[28], req.write_data[26]};
               s.qcount = (req.write_data[11:0] == 12'd0) ? sdc_pkg::COUNT_FULL
                                                           : {1'b0, req.write_data[11:0]};
               s.qflags = {req.write_data[27], req.write_data[25], req.write_data[24]};
               s.qsel   = req.write_data[17:16];
               if (req.write_data[26]) s = end_txn(s, mask_ff);
               s = refresh(s);
            end
            sdc_pkg::REG_SETUP4: s.sw4 = req.write_data[11:0];
            sdc_pkg::REG_SEND: begin
               if (s.qcount != 13'd0 && s.qflags[sdc_pkg::FL_SEND_BIT] && is_idle(s))
                  s = promote(s, mask_ff);
               if (s.scnt != 13'd0) begin
                  s.scnt = s.scnt - 13'd1;
                  if (attached(s.csel, mask_ff)) begin
                     xch  = 1'b1;
                     sout = req.write_data[7:0];
                  end
                  if (is_idle(s)) s = finish(s, mask_ff);
               end else begin
                  err = sdc_pkg::ERR_EMPTY;
               end
               s.ris[1] = 1'b1;
            end
            sdc_pkg::REG_RD_EN:  s.rie = req.write_data[3:0];
            sdc_pkg::REG_RD_CLR: s.ris = s.ris & ~req.write_data[3:0];
            sdc_pkg::REG_WR_EN:  s.wie = req.write_data[4:0];
            sdc_pkg::REG_WR_CLR: s.wis = s.wis & ~req.write_data[4:0];
            default: ;
         endcase
      end else begin
         unique case (regi)
            sdc_pkg::REG_SETUP0: rd = s.sw0;
            sdc_pkg::REG_SETUP1: rd = s.sw1;
            sdc_pkg::REG_SETUP2: rd = s.sw2;
            sdc_pkg::REG_CONTROL: begin
               rd = {2'b00, s.ctl[2], s.ctl[1], s.qflags[2], s.ctl[0], s.qflags[1],
                     s.qflags[0], 6'd0, s.qsel, 3'd0, s.qcount};
            end
            sdc_pkg::REG_SETUP4: rd = {20'd0, s.sw4};
            sdc_pkg::REG_GET: begin
               rd = 32'h0000_00ff;
               if (s.qcount != 13'd0 && s.qflags[sdc_pkg::FL_RECV_BIT] && is_idle(s))
                  s = promote(s, mask_ff);
               if (s.rcnt != 13'd0) begin
                  s.rcnt = s.rcnt - 13'd1;
                  if (attached(s.csel, mask_ff)) begin
                     xch  = 1'b1;
                     sout = 8'hff;
                     rd   = {24'd0, req.slave_in_byte};
                  end
                  if (is_idle(s)) s = finish(s, mask_ff);
               end else begin
                  err = sdc_pkg::ERR_EMPTY;
               end
            end
            sdc_pkg::REG_RD_STAT: rd = {28'd0, s.ris};
            sdc_pkg::REG_RD_EN:   rd = {28'd0, s.rie};
            sdc_pkg::REG_WR_STAT: rd = {27'd0, s.wis};
            sdc_pkg::REG_WR_EN:   rd = {27'd0, s.wie};
            default: ;
         endcase
      end
      state_in = s;
      rsp_in.read_data      = rd;
      rsp_in.byte_exchanged = xch;
      rsp_in.slave_out_byte = sout;
      rsp_in.active_select  = s.csel;
      rsp_in.release_mask   = s.rel;
      rsp_in.tx_dma_request = s.dma[0];
      rsp_in.rx_dma_request = s.dma[1];
      rsp_in.access_error   = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         mask_ff  <= 3'b111;
         rsp_ff   <= '0;
      end else begin
         if (csr_write_enable) mask_ff <= csr_write_data;
         if (cmd.commit) begin
            state_ff <= state_in;
            rsp_ff   <= rsp_in;
         end
      end
   end

   assign rsp = rsp_ff;

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.access_error != 2'd3)
      else $error("undefined access error code");

   a_xch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.byte_exchanged |-> (rsp_ff.access_error == sdc_pkg::ERR_OK))
      else $error("byte exchanged on a failed access");

   a_release_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.release_mask & ~SEL_MASK) == 3'b000)
      else $error("release of a select beyond the configured count");

   // A busy transfer never raises a DMA request.
   a_dma_idle: assert property (@(posedge clock) disable iff (reset)
      !is_idle(state_ff) |-> (state_ff.dma == 2'b00))
      else $error("DMA request while a transfer is in progress");

endmodule

@@ sv/spi_dma_descriptor_controller_unit.sv @@
// SPI controller register block with queued transfers and DMA request levels.
// The req_ch channel carries one register access per transfer: cmd (0 read,
// 1 write), byte_address, write_data and the byte returned by the selected
// slave. Each accepted access yields exactly one result on rsp_ch: read data,
// the byte exchanged with the slave, the active chip select, the selects
// released by this access, both DMA request levels and an error code.
// The csr_ port writes the device-present mask (one bit per chip select).
// An access is accepted and its result is registered on the same edge, so
// rsp_ch.valid rises in the cycle after acceptance. The block handles
// one access at a time: a new access is accepted in the cycle after the
// result transfer. The controller state machine alone sets this pacing.
// While the receiver stalls, the result is held and req_ch.ready stays low.
// Reset clears all transfer state, sets the interrupt status registers to
// their idle values and the device-present mask to all ones.
module spi_dma_descriptor_controller_unit #(
   parameter int NUM_SELECTS = 3
) (
   input  logic            clock,
   input  logic            reset,
   sdc_req_if.sink         req_ch,
   sdc_rsp_if.source       rsp_ch,
   input  logic            csr_write_enable,
   input  logic [2:0]      csr_write_data
);

   sdc_pkg::sdc_cmd_type cmd;
   sdc_pkg::sdc_req_type req;
   sdc_pkg::sdc_rsp_type rsp;

   assign req.cmd           = req_ch.cmd;
   assign req.byte_address  = req_ch.byte_address;
   assign req.write_data    = req_ch.write_data;
   assign req.slave_in_byte = req_ch.slave_in_byte;

   sdc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   sdc_datapath #(
      .NUM_SELECTS (NUM_SELECTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req              (req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp              (rsp)
   );

   assign rsp_ch.read_data      = rsp.read_data;
   assign rsp_ch.byte_exchanged = rsp.byte_exchanged;
   assign rsp_ch.slave_out_byte = rsp.slave_out_byte;
   assign rsp_ch.active_select  = rsp.active_select;
   assign rsp_ch.release_mask   = rsp.release_mask;
   assign rsp_ch.tx_dma_request = rsp.tx_dma_request;
   assign rsp_ch.rx_dma_request = rsp.rx_dma_request;
   assign rsp_ch.access_error   = rsp.access_error;

endmodule
